### hdl/sbsag_pkg.sv
// Shared types and constants for the scaled blit source address generator.
// No dependencies; every other file of the block uses this package.
package sbsag_pkg;

   localparam int INDEX_W     = 40;   // Q24.16 source index
   localparam int WIDTH_W     = 13;   // image width register
   localparam int ROW_FRAC_W  = 16;   // fractional row position
   localparam int STEP_W      = 24;   // Q8.16 steps
   localparam int STEP_FRAC_W = 16;
   localparam int LOOP_W      = 13;   // loop count registers
   localparam int COUNT_W     = 12;   // column and row counters
   localparam int MIRROR_W    = 2;
   localparam int CSR_DATA_W  = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int DIFF_W      = STEP_W - STEP_FRAC_W + 1;  // row change, 0..256
   localparam int PROD_W      = WIDTH_W + DIFF_W;

   localparam logic [LOOP_W-1:0]  LOOP_LIMIT = LOOP_W'(4096);
   localparam logic [INDEX_W-1:0] INDEX_MAX  = {INDEX_W{1'b1}};

   localparam int MIRROR_H = 0;
   localparam int MIRROR_V = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_START_INDEX     = 3'd1,
      CSR_START_ROW_FRAC  = 3'd2,
      CSR_STEP_X          = 3'd3,
      CSR_STEP_Y          = 3'd4,
      CSR_COLUMNS_PER_ROW = 3'd5,
      CSR_ROWS_PER_PASS   = 3'd6,
      CSR_MIRROR_MODE     = 3'd7
   } csr_index_type;

   // Clamp a loop count: zero runs once, anything above the limit runs the limit.
   function automatic logic [LOOP_W-1:0] loop_len(input logic [LOOP_W-1:0] v);
      logic [LOOP_W-1:0] r;
      if (v == '0) begin
         r = LOOP_W'(1);
      end else if (v > LOOP_LIMIT) begin
         r = LOOP_LIMIT;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### hdl/sbsag_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on sbsag_pkg for the payload widths.
interface sbsag_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

interface sbsag_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbsag_pkg::INDEX_W-1:0] pixel_index;
   logic                        pass_done;

   modport source (output valid, output pixel_index, output pass_done, input ready);
   modport sink   (input valid, input pixel_index, input pass_done, output ready);
endinterface

### hdl/scaled_blit_source_address_generator.sv
// Scaled blit source address generator: one Q24.16 source index per request.
// Depends on sbsag_pkg and the channel interfaces in sbsag_if.sv.
//
// Usage:
//  - req channel: each transfer with advance high asks for the next source
//    index; a transfer with advance low is consumed and changes nothing.
//  - rsp channel: one transfer per request, carrying pixel_index (Q24.16,
//    saturated) and pass_done, high when that step closed the pass and the
//    start values were reloaded.
//  - csr port: write enable, register index and data; program the registers
//    only while no request is in flight. The start values are picked up at the
//    first request after reset and at every pass end.
//  - Result: registered, valid in the cycle after its request transfer.
//  - Throughput: one request per cycle while rsp.ready is high. The limiting
//    path is the row move: a small width-by-row-change multiply followed by a
//    40-bit saturating add or subtract into the result register.
//  - Reset: configuration returns to its defaults, counters clear and the
//    block waits for its first request, which returns start_index.
//  - Stall: the result register holds while rsp.ready is low and req.ready
//    drops with it; a waiting result is replaced in the same cycle it leaves.
module scaled_blit_source_address_generator #(
   parameter int MAX_IMAGE_WIDTH = 4096,
   parameter int INDEX_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   sbsag_req_if.sink                           req,
   sbsag_rsp_if.source                         rsp,
   input  logic                                csr_wr_en,
   input  logic [sbsag_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbsag_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import sbsag_pkg::*;

   localparam int MOVE_W = PROD_W + INDEX_FRAC_BITS;
   localparam int SUM_W  = ((MOVE_W > INDEX_W) ? MOVE_W : INDEX_W) + 1;

   // Configuration registers
   logic [WIDTH_W-1:0]    image_width_ff;
   logic [INDEX_W-1:0]    start_index_ff;
   logic [ROW_FRAC_W-1:0] start_row_frac_ff;
   logic [STEP_W-1:0]     step_x_ff;
   logic [STEP_W-1:0]     step_y_ff;
   logic [LOOP_W-1:0]     columns_ff;
   logic [LOOP_W-1:0]     rows_ff;
   logic [MIRROR_W-1:0]   mirror_ff;

   // Walk state
   logic                  started_ff,      started_in;
   logic [COUNT_W-1:0]    column_count_ff, column_count_in;
   logic [COUNT_W-1:0]    row_count_ff,    row_count_in;
   logic [INDEX_W-1:0]    current_ff,      current_in;
   logic [INDEX_W-1:0]    row_start_ff,    row_start_in;
   logic [ROW_FRAC_W-1:0] row_frac_ff,     row_frac_in;

   // Result register
   logic                  rsp_valid_ff,    rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_index_ff,    rsp_index_in;
   logic                  rsp_done_ff,     rsp_done_in;

   logic                  step;
   logic [LOOP_W-1:0]     next_col;
   logic [LOOP_W-1:0]     next_row;
   logic                  row_end;
   logic                  pass_end;
   logic [INDEX_W:0]      h_sum;
   logic [INDEX_W-1:0]    h_add;
   logic [INDEX_W-1:0]    h_sub;
   logic [INDEX_W-1:0]    h_next;
   logic [ROW_FRAC_W:0]   frac_sum;
   logic [DIFF_W-1:0]     row_diff;
   logic [WIDTH_W-1:0]    width_eff;
   logic [PROD_W-1:0]     move_pixels;
   logic [MOVE_W-1:0]     move;
   logic [SUM_W-1:0]      v_sum;
   logic [SUM_W-1:0]      v_dif;
   logic [INDEX_W-1:0]    v_add;
   logic [INDEX_W-1:0]    v_sub;
   logic [INDEX_W-1:0]    row_moved;

   // A new request can enter whenever the result slot is empty or draining.
   assign req.ready       = !rsp_valid_ff || rsp.ready;
   assign step            = req.valid && req.ready && req.advance;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_index = rsp_index_ff;
   assign rsp.pass_done   = rsp_done_ff;

   // Loop position
   assign next_col = LOOP_W'(column_count_ff) + LOOP_W'(1);
   assign next_row = LOOP_W'(row_count_ff) + LOOP_W'(1);
   assign row_end  = next_col >= loop_len(columns_ff);
   assign pass_end = row_end && (next_row >= loop_len(rows_ff));

   // Horizontal step, saturating at both ends
   assign h_sum  = {1'b0, current_ff} + (INDEX_W + 1)'(step_x_ff);
   assign h_add  = h_sum[INDEX_W] ? INDEX_MAX : h_sum[INDEX_W-1:0];
   assign h_sub  = (INDEX_W'(step_x_ff) > current_ff) ? '0
                                                     : current_ff - INDEX_W'(step_x_ff);
   assign h_next = mirror_ff[MIRROR_H] ? h_sub : h_add;

   // Row accumulator: the integer part moves by the step's integer part plus
   // the carry out of the fraction, so only the fraction needs storing.
   assign frac_sum  = {1'b0, row_frac_ff} + {1'b0, step_y_ff[STEP_FRAC_W-1:0]};
   assign row_diff  = DIFF_W'(step_y_ff[STEP_W-1:STEP_FRAC_W]) + DIFF_W'(frac_sum[ROW_FRAC_W]);
   assign width_eff = (32'(image_width_ff) > MAX_IMAGE_WIDTH) ? WIDTH_W'(MAX_IMAGE_WIDTH)
                                                             : image_width_ff;
   assign move_pixels = PROD_W'(width_eff) * PROD_W'(row_diff);
   assign move        = {move_pixels, {INDEX_FRAC_BITS{1'b0}}};

   // Vertical move of the row start, saturating at both ends
   assign v_sum = SUM_W'(row_start_ff) + SUM_W'(move);
   assign v_dif = SUM_W'(row_start_ff) - SUM_W'(move);
   assign v_add = (v_sum > SUM_W'(INDEX_MAX)) ? INDEX_MAX : v_sum[INDEX_W-1:0];
   assign v_sub = (SUM_W'(move) > SUM_W'(row_start_ff)) ? '0 : v_dif[INDEX_W-1:0];
   assign row_moved = (row_diff == '0)       ? row_start_ff :
                      mirror_ff[MIRROR_V]    ? v_sub        : v_add;

   always_comb begin
      started_in      = started_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      current_in      = current_ff;
      row_start_in    = row_start_ff;
      row_frac_in     = row_frac_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_done_in     = rsp_done_ff;
      // Hold a stalled result, drop it once taken.
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = 1'b0;
         if (!started_ff || pass_end) begin
            // Load the start values; a pass end also flags the restart.
            started_in      = 1'b1;
            column_count_in = '0;
            row_count_in    = '0;
            current_in      = start_index_ff;
            row_start_in    = start_index_ff;
            row_frac_in     = start_row_frac_ff;
            rsp_index_in    = start_index_ff;
            rsp_done_in     = started_ff;
         end else if (row_end) begin
            // Return to the row start, moved by whole source rows.
            column_count_in = '0;
            row_count_in    = next_row[COUNT_W-1:0];
            row_frac_in     = frac_sum[ROW_FRAC_W-1:0];
            row_start_in    = row_moved;
            current_in      = row_moved;
            rsp_index_in    = row_moved;
         end else begin
            column_count_in = next_col[COUNT_W-1:0];
            current_in      = h_next;
            rsp_index_in    = h_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= WIDTH_W'(1);
         start_index_ff    <= '0;
         start_row_frac_ff <= '0;
         step_x_ff         <= STEP_W'(65536);
         step_y_ff         <= STEP_W'(65536);
         columns_ff        <= LOOP_W'(1);
         rows_ff           <= LOOP_W'(1);
         mirror_ff         <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     image_width_ff    <= csr_wr_data[WIDTH_W-1:0];
            CSR_START_INDEX:     start_index_ff    <= csr_wr_data[INDEX_W-1:0];
            CSR_START_ROW_FRAC:  start_row_frac_ff <= csr_wr_data[ROW_FRAC_W-1:0];
            CSR_STEP_X:          step_x_ff         <= csr_wr_data[STEP_W-1:0];
            CSR_STEP_Y:          step_y_ff         <= csr_wr_data[STEP_W-1:0];
            CSR_COLUMNS_PER_ROW: columns_ff        <= csr_wr_data[LOOP_W-1:0];
            CSR_ROWS_PER_PASS:   rows_ff           <= csr_wr_data[LOOP_W-1:0];
            CSR_MIRROR_MODE:     mirror_ff         <= csr_wr_data[MIRROR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         started_ff      <= started_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Datapath: the first request reloads everything, so no reset is needed.
   always_ff @(posedge clock) begin
      current_ff   <= current_in;
      row_start_ff <= row_start_in;
      row_frac_ff  <= row_frac_in;
      rsp_index_ff <= rsp_index_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Counters stay clear until the first request has loaded the pass.
   a_idle_counts: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (column_count_ff == '0) && (row_count_ff == '0))
      else $error("counters moved before the first request");

   // Every request leaves a result in the output register.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("request produced no result");

   // The first request returns the start index without a pass flag.
   a_first_start: assert property (@(posedge clock) disable iff (reset)
      step && !started_ff |=> (rsp_index_ff == $past(start_index_ff)) && !rsp_done_ff)
      else $error("first result is not the start index");

   // A pass end restarts at the start index with counters cleared.
   a_pass_restart: assert property (@(posedge clock) disable iff (reset)
      step && started_ff && pass_end |=> rsp_done_ff
         && (rsp_index_ff == $past(start_index_ff)) && (current_ff == rsp_index_ff)
         && (column_count_ff == '0) && (row_count_ff == '0))
      else $error("pass end did not restart the walk");

   // A flagged result only comes from a step that ended a pass.
   a_done_source: assert property (@(posedge clock) disable iff (reset)
      step && !(started_ff && pass_end) |=> !rsp_done_ff)
      else $error("pass flag raised outside a pass end");

endmodule
